### hdl/lastd_pkg.sv
// Shared types, register codes and constant functions for the leaf/soil derivative block.
`default_nettype none
package lastd_pkg;

  // Register indexes on the configuration port (byte address is 4 times the index).
  localparam logic [2:0] REG_SOIL_EXTINCTION    = 3'd0;
  localparam logic [2:0] REG_SOIL_EXCHANGE_RATE = 3'd1;
  localparam logic [2:0] REG_GROWTH_RATE        = 3'd2;
  localparam logic [2:0] REG_LEAF_FLOOR         = 3'd3;
  localparam logic [2:0] REG_LEAF_CEILING       = 3'd4;
  localparam logic [2:0] REG_BASE_TEMPERATURE   = 3'd5;
  localparam logic [2:0] REG_DECAY_RATE         = 3'd6;

  // Register reset values.
  localparam logic [15:0] RST_SOIL_EXTINCTION    = 16'd2048;
  localparam logic [15:0] RST_SOIL_EXCHANGE_RATE = 16'd410;
  localparam logic [15:0] RST_GROWTH_RATE        = 16'd41;
  localparam logic [11:0] RST_LEAF_FLOOR         = 12'd128;
  localparam logic [11:0] RST_LEAF_CEILING       = 12'd1536;
  localparam logic [15:0] RST_BASE_TEMPERATURE   = 16'd1280;
  localparam logic [15:0] RST_DECAY_RATE         = 16'd41;

  // Raw leaf change is clamped to plus or minus 2^40 in Q16.16.
  localparam logic [40:0] LEAF_LIM = 41'h10000000000;
  // The value 0.1 in Q16.16.
  localparam logic [21:0] TENTH_Q16 = 22'd6554;
  // exp(-1) in Q30.
  localparam logic [63:0] EXPM1_Q30 = 64'd395007542;

  // Side data that rides along the first divider.
  typedef struct packed {
    logic               neg;
    logic               fsat;
    logic signed [12:0] s;
    logic [31:0]        soil;
  } div1_side_t;

  // Side data that rides along the second divider.
  typedef struct packed {
    logic        sgn;
    logic        pos;
    logic [31:0] leafp;
    logic [31:0] soil;
  } div2_side_t;

  // Grid point of exp(-y) in Q24, where y is given in Q30.
  // A Taylor series covers the fraction and repeated products by exp(-1) the integer part.
  function automatic logic [24:0] grid_point(input logic [63:0] y);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rnd;
    n    = y >> 30;
    f    = y & ((64'd1 << 30) - 64'd1);
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * f) >> 30) / 64'(k);
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int k = 0; k < 16; k++) begin
      if (64'(k) < n) begin
        sum = (sum * EXPM1_Q30 + (64'd1 << 29)) >> 30;
      end
    end
    rnd = (sum + 64'd32) >> 6;
    return rnd[24:0];
  endfunction

endpackage
`default_nettype wire

### hdl/lastd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation on overflow.
`default_nettype none
module lastd_div #(
  parameter int NW = 47,
  parameter int DW = 12,
  parameter int QB = 41,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_v,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [QB-1:0] out_q,
  output logic [SW-1:0] out_side
);

  logic          v_r    [0:QB];
  logic [NW-1:0] rem_r  [0:QB-1];
  logic [DW-1:0] den_r  [0:QB-1];
  logic [QB-1:0] q_r    [0:QB];
  logic          ovf_r  [0:QB];
  logic [SW-1:0] side_r [0:QB];
  logic [NW-1:0] num_hi;

  // A quotient that needs more than QB bits is flagged and saturates at the end.
  assign num_hi = in_num >> QB;

  // Entry stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= in_num;
      den_r[0]  <= in_den;
      q_r[0]    <= '0;
      ovf_r[0]  <= (num_hi >= {{(NW-DW){1'b0}}, in_den});
      side_r[0] <= in_side;
    end
  end

  // One stage per quotient bit, most significant bit first.
  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int B = QB - j;
    logic [NW-1:0] den_ext;
    logic [NW-1:0] rem_sh;
    logic [NW-1:0] sub;
    logic          take;

    assign den_ext = {{(NW-DW){1'b0}}, den_r[j-1]};
    assign rem_sh  = rem_r[j-1] >> B;
    assign take    = !ovf_r[j-1] && (rem_sh >= den_ext);
    assign sub     = rem_r[j-1] - (den_ext << B);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[j]    <= q_r[j-1] | (QB'(take) << B);
        ovf_r[j]  <= ovf_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end

    // The last stage needs no remainder.
    if (j < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j] <= take ? sub : rem_r[j-1];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  assign out_v    = v_r[QB];
  assign out_q    = ovf_r[QB] ? '1 : q_r[QB];
  assign out_side = side_r[QB];

endmodule
`default_nettype wire

### hdl/leaf_area_soil_temp_derivative_top.sv
// Top level of the leaf area and soil temperature derivative pipeline with its register port.
// Throughput: one item per cycle while the output is not stalled; the two pipelined dividers
// (41 and 32 quotient-bit stages, each after an entry stage) set the depth.
// A stall on a valid output freezes every stage at once, so nothing is dropped or repeated.
// Reset clears all valid bits and loads the registers with their default values.
// The interpolated exp(-x) grid is a constant table built at elaboration.
`default_nettype none
module leaf_area_soil_temp_derivative_top #(
  parameter int EXP_SEGMENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_leaf_area,
  input  logic signed [15:0] in_soil_temp,
  input  logic signed [15:0] in_air_temp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_leaf_rate,
  output logic signed [31:0] out_soil_rate,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = $clog2(EXP_SEGMENTS + 1);
  localparam int PW = 24 + IW;

  // Configuration registers.
  logic [15:0] ext_r;
  logic [15:0] xrate_r;
  logic [15:0] growth_r;
  logic [11:0] floor_r;
  logic [11:0] ceil_r;
  logic [15:0] base_r;
  logic [15:0] decay_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r    <= lastd_pkg::RST_SOIL_EXTINCTION;
      xrate_r  <= lastd_pkg::RST_SOIL_EXCHANGE_RATE;
      growth_r <= lastd_pkg::RST_GROWTH_RATE;
      floor_r  <= lastd_pkg::RST_LEAF_FLOOR;
      ceil_r   <= lastd_pkg::RST_LEAF_CEILING;
      base_r   <= lastd_pkg::RST_BASE_TEMPERATURE;
      decay_r  <= lastd_pkg::RST_DECAY_RATE;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        lastd_pkg::REG_SOIL_EXTINCTION:    ext_r    <= pwdata[15:0];
        lastd_pkg::REG_SOIL_EXCHANGE_RATE: xrate_r  <= pwdata[15:0];
        lastd_pkg::REG_GROWTH_RATE:        growth_r <= pwdata[15:0];
        lastd_pkg::REG_LEAF_FLOOR:         floor_r  <= pwdata[11:0];
        lastd_pkg::REG_LEAF_CEILING:       ceil_r   <= pwdata[11:0];
        lastd_pkg::REG_BASE_TEMPERATURE:   base_r   <= pwdata[15:0];
        lastd_pkg::REG_DECAY_RATE:         decay_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[4:2])
      lastd_pkg::REG_SOIL_EXTINCTION:    prdata = {16'd0, ext_r};
      lastd_pkg::REG_SOIL_EXCHANGE_RATE: prdata = {16'd0, xrate_r};
      lastd_pkg::REG_GROWTH_RATE:        prdata = {16'd0, growth_r};
      lastd_pkg::REG_LEAF_FLOOR:         prdata = {20'd0, floor_r};
      lastd_pkg::REG_LEAF_CEILING:       prdata = {20'd0, ceil_r};
      lastd_pkg::REG_BASE_TEMPERATURE:   prdata = {16'd0, base_r};
      lastd_pkg::REG_DECAY_RATE:         prdata = {16'd0, decay_r};
      default:                           prdata = 32'd0;
    endcase
  end

  // Global advance: the whole pipeline moves unless a finished result is held.
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Constant exp(-x) grid over x in [0,16].
  logic [24:0] grid_w [0:EXP_SEGMENTS];
  for (genvar gi = 0; gi <= EXP_SEGMENTS; gi++) begin : g_grid
    localparam logic [63:0] GY = (64'(gi) << 34) / 64'(EXP_SEGMENTS);
    assign grid_w[gi] = lastd_pkg::grid_point(GY);
  end

  // Stage 1: temperature excess and deficit products, shading argument, soil drive.
  logic signed [16:0] up_diff;
  logic signed [16:0] dn_diff;
  logic [15:0]        up16;
  logic [15:0]        dn16;
  logic [31:0]        g_full;
  logic [31:0]        d_full;
  logic [27:0]        x_full;
  logic signed [16:0] td;
  logic signed [33:0] e_full;

  assign up_diff = {in_air_temp[15], in_air_temp} - {base_r[15], base_r};
  assign dn_diff = {base_r[15], base_r} - {in_air_temp[15], in_air_temp};
  assign up16    = (!up_diff[16] && up_diff != 17'sd0) ? up_diff[15:0] : 16'd0;
  assign dn16    = (!dn_diff[16] && dn_diff != 17'sd0) ? dn_diff[15:0] : 16'd0;
  assign g_full  = growth_r * up16;
  assign d_full  = decay_r * dn16;
  assign x_full  = ext_r * in_leaf_area;
  assign td      = {in_air_temp[15], in_air_temp} - {in_soil_temp[15], in_soil_temp};
  assign e_full  = $signed({1'b0, xrate_r}) * td;

  logic               v1_r;
  logic [31:0]        g1_r;
  logic [31:0]        d1_r;
  logic signed [12:0] cm1_r;
  logic [11:0]        l1_r;
  logic [27:0]        x1_r;
  logic signed [32:0] e1_r;
  logic               gt1_r;
  logic               tsp1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r   <= g_full;
      d1_r   <= d_full;
      cm1_r  <= {1'b0, ceil_r} - {1'b0, in_leaf_area};
      l1_r   <= in_leaf_area;
      x1_r   <= x_full;
      e1_r   <= e_full[32:0];
      gt1_r  <= in_air_temp > in_soil_temp;
      tsp1_r <= in_soil_temp > 16'sd0;
    end
  end

  // Stage 2: growth times headroom, decay times leaf area, grid position.
  logic signed [45:0] a_full;
  logic [43:0]        b_full;
  logic [PW-1:0]      p_full;

  assign a_full = $signed({1'b0, g1_r}) * cm1_r;
  assign b_full = d1_r * l1_r;
  assign p_full = x1_r[23:0] * PW'(EXP_SEGMENTS);

  logic               v2_r;
  logic signed [44:0] a2_r;
  logic [43:0]        b2_r;
  logic [11:0]        l2_r;
  logic               big2_r;
  logic [IW-1:0]      idx2_r;
  logic [23:0]        fr2_r;
  logic signed [32:0] e2_r;
  logic               gt2_r;
  logic               tsp2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r   <= a_full[44:0];
      b2_r   <= b_full;
      l2_r   <= l1_r;
      big2_r <= |x1_r[27:24];
      idx2_r <= p_full[PW-1:24];
      fr2_r  <= p_full[23:0];
      e2_r   <= e1_r;
      gt2_r  <= gt1_r;
      tsp2_r <= tsp1_r;
    end
  end

  // Stage 3: the two logistic products and the grid lookup.
  logic signed [57:0] gn_full;
  logic [55:0]        dn_full;
  logic [IW-1:0]      idx_a;
  logic [IW-1:0]      idx_b;
  logic [24:0]        ga;
  logic [24:0]        gb;

  assign gn_full = a2_r * $signed({1'b0, l2_r});
  assign dn_full = b2_r * ceil_r;
  assign idx_a   = big2_r ? IW'(EXP_SEGMENTS) : idx2_r;
  assign idx_b   = big2_r ? IW'(EXP_SEGMENTS) : idx2_r + IW'(1);
  assign ga      = grid_w[idx_a];
  assign gb      = grid_w[idx_b];

  logic               v3_r;
  logic signed [56:0] gn3_r;
  logic [55:0]        dn3_r;
  logic [43:0]        b3_r;
  logic [11:0]        l3_r;
  logic [24:0]        ga3_r;
  logic signed [25:0] gd3_r;
  logic [23:0]        fr3_r;
  logic signed [32:0] e3_r;
  logic               gt3_r;
  logic               tsp3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gn3_r  <= gn_full[56:0];
      dn3_r  <= dn_full;
      b3_r   <= b2_r;
      l3_r   <= l2_r;
      ga3_r  <= ga;
      gd3_r  <= {1'b0, ga} - {1'b0, gb};
      fr3_r  <= big2_r ? 24'd0 : fr2_r;
      e3_r   <= e2_r;
      gt3_r  <= gt2_r;
      tsp3_r <= tsp2_r;
    end
  end

  // Stage 4: raw leaf numerator and the interpolation product.
  logic signed [58:0] num_full;
  logic signed [50:0] t_full;

  assign num_full = $signed({{2{gn3_r[56]}}, gn3_r}) - $signed({3'b0, dn3_r});
  assign t_full   = gd3_r * $signed({1'b0, fr3_r});

  logic               v4_r;
  logic signed [58:0] num4_r;
  logic [43:0]        b4_r;
  logic [11:0]        l4_r;
  logic [24:0]        ga4_r;
  logic signed [49:0] t4_r;
  logic signed [32:0] e4_r;
  logic               gt4_r;
  logic               tsp4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num4_r <= num_full;
      b4_r   <= b3_r;
      l4_r   <= l3_r;
      ga4_r  <= ga3_r;
      t4_r   <= t_full[49:0];
      e4_r   <= e3_r;
      gt4_r  <= gt3_r;
      tsp4_r <= tsp3_r;
    end
  end

  // Stage 5: sign and magnitude of the leaf numerator; finished damping factor.
  // With a zero ceiling only the decay term counts, unless the growth term is nonzero.
  logic               cz;
  logic [58:0]        num_abs;
  logic signed [50:0] fsum;
  logic [24:0]        fac_nxt;

  assign cz      = (ceil_r == 12'd0);
  assign num_abs = num4_r[58] ? -num4_r : num4_r;
  assign fsum    = $signed({2'b0, ga4_r, 24'd0}) - {t4_r[49], t4_r} + 51'sd8388608;
  assign fac_nxt = gt4_r ? fsum[48:24] : 25'h1000000;

  logic               v5_r;
  logic [57:0]        mag5_r;
  logic [22:0]        cadd5_r;
  logic               neg5_r;
  logic               fsat5_r;
  logic [11:0]        div5_r;
  logic [11:0]        l5_r;
  logic [24:0]        fac5_r;
  logic signed [32:0] e5_r;
  logic               tsp5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag5_r  <= cz ? {14'd0, b4_r} : num_abs[57:0];
      cadd5_r <= cz ? 23'd2048 : {ceil_r, 11'd0};
      neg5_r  <= cz ? 1'b1 : num4_r[58];
      fsat5_r <= cz && (num4_r != 59'sd0);
      div5_r  <= cz ? 12'd1 : ceil_r;
      l5_r    <= l4_r;
      fac5_r  <= fac_nxt;
      e5_r    <= e4_r;
      tsp5_r  <= tsp4_r;
    end
  end

  // Stage 6: rounded dividend for the leaf division; soil product.
  logic [58:0]        lsum;
  logic signed [58:0] n_full;

  assign lsum   = {1'b0, mag5_r} + {36'd0, cadd5_r};
  assign n_full = e5_r * $signed({1'b0, fac5_r});

  logic               v6_r;
  logic [46:0]        dvd6_r;
  logic               neg6_r;
  logic               fsat6_r;
  logic [11:0]        div6_r;
  logic [11:0]        l6_r;
  logic signed [57:0] n6_r;
  logic               tsp6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd6_r  <= lsum[58:12];
      neg6_r  <= neg5_r;
      fsat6_r <= fsat5_r;
      div6_r  <= div5_r;
      l6_r    <= l5_r;
      n6_r    <= n_full[57:0];
      tsp6_r  <= tsp5_r;
    end
  end

  // Stage 7: soil rate rounded into Q16.16 and gated; leaf surplus over the floor.
  logic [57:0] nabs;
  logic [57:0] qsum;
  logic [29:0] q30;
  logic [31:0] q32;
  logic [31:0] soil_nxt;

  assign nabs     = n6_r[57] ? -n6_r : n6_r;
  assign qsum     = nabs + 58'd134217728;
  assign q30      = qsum[57:28];
  assign q32      = {2'd0, q30};
  assign soil_nxt = ((!n6_r[57] && q30 != 30'd0) || tsp6_r) ? (n6_r[57] ? -q32 : q32) : 32'd0;

  logic               v7_r;
  logic [46:0]        dvd7_r;
  logic [11:0]        div7_r;
  lastd_pkg::div1_side_t side7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd7_r       <= dvd6_r;
      div7_r       <= div6_r;
      side7_r.neg  <= neg6_r;
      side7_r.fsat <= fsat6_r;
      side7_r.s    <= {1'b0, l6_r} - {1'b0, floor_r};
      side7_r.soil <= soil_nxt;
    end
  end

  // Leaf change divided by ceiling times 4096.
  logic                  d1_v;
  logic [40:0]           d1_q;
  lastd_pkg::div1_side_t d1_side;

  lastd_div #(
    .NW(47),
    .DW(12),
    .QB(41),
    .SW($bits(lastd_pkg::div1_side_t))
  ) u_div_leaf (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (v7_r),
    .in_num  (dvd7_r),
    .in_den  (div7_r),
    .in_side (side7_r),
    .out_v   (d1_v),
    .out_q   (d1_q),
    .out_side(d1_side)
  );

  // Middle stage 1: clamp, sign handling and the slowdown divisor s*256 + 0.1.
  logic [40:0]        mag_nxt;
  logic [12:0]        s_neg;
  logic [11:0]        sabs_nxt;
  logic [21:0]        den;
  logic [21:0]        den_neg;

  assign mag_nxt  = (d1_side.fsat || d1_q > lastd_pkg::LEAF_LIM) ? lastd_pkg::LEAF_LIM : d1_q;
  assign s_neg    = -d1_side.s;
  assign sabs_nxt = d1_side.s[12] ? s_neg[11:0] : d1_side.s[11:0];
  assign den      = {d1_side.s[12], d1_side.s, 8'd0} + lastd_pkg::TENTH_Q16;
  assign den_neg  = -den;

  logic                  vm1_r;
  logic [40:0]           mag_m1_r;
  logic [11:0]           sabs_m1_r;
  logic [20:0]           dmag_m1_r;
  lastd_pkg::div2_side_t side_m1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else if (adv) begin
      vm1_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_m1_r        <= mag_nxt;
      sabs_m1_r       <= sabs_nxt;
      dmag_m1_r       <= den[21] ? den_neg[20:0] : den[20:0];
      side_m1_r.sgn   <= d1_side.neg ^ d1_side.s[12] ^ den[21];
      side_m1_r.pos   <= !d1_side.neg && (mag_nxt != 41'd0);
      side_m1_r.leafp <= (mag_nxt > 41'h7fffffff) ? 32'h7fffffff : mag_nxt[31:0];
      side_m1_r.soil  <= d1_side.soil;
    end
  end

  // Middle stage 2: leaf change magnitude times surplus.
  logic [52:0] prod_full;
  assign prod_full = mag_m1_r * sabs_m1_r;

  logic                  vm2_r;
  logic [52:0]           prod_m2_r;
  logic [20:0]           dmag_m2_r;
  lastd_pkg::div2_side_t side_m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else if (adv) begin
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_m2_r <= prod_full;
      dmag_m2_r <= dmag_m1_r;
      side_m2_r <= side_m1_r;
    end
  end

  // Middle stage 3: scale by 256 and add half the divisor for rounding.
  logic                  vm3_r;
  logic [61:0]           dvd_m3_r;
  logic [20:0]           dmag_m3_r;
  lastd_pkg::div2_side_t side_m3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm3_r <= 1'b0;
    end else if (adv) begin
      vm3_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd_m3_r  <= {1'b0, prod_m2_r, 8'd0} + {42'd0, dmag_m2_r[20:1]};
      dmag_m3_r <= dmag_m2_r;
      side_m3_r <= side_m2_r;
    end
  end

  // Slowdown division near the leaf floor.
  logic                  d2_v;
  logic [31:0]           d2_q;
  lastd_pkg::div2_side_t d2_side;

  lastd_div #(
    .NW(62),
    .DW(21),
    .QB(32),
    .SW($bits(lastd_pkg::div2_side_t))
  ) u_div_slow (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (vm3_r),
    .in_num  (dvd_m3_r),
    .in_den  (dmag_m3_r),
    .in_side (side_m3_r),
    .out_v   (d2_v),
    .out_q   (d2_q),
    .out_side(d2_side)
  );

  // Output register: saturate the slowed leaf change, or pass a growing one.
  logic [31:0] leaf_nxt;
  logic [31:0] leaf_r;
  logic [31:0] soil_r;

  always_comb begin
    if (d2_side.pos) begin
      leaf_nxt = d2_side.leafp;
    end else if (d2_side.sgn) begin
      leaf_nxt = d2_q[31] ? 32'h80000000 : -d2_q;
    end else begin
      leaf_nxt = d2_q[31] ? 32'h7fffffff : d2_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      leaf_r <= leaf_nxt;
      soil_r <= d2_side.soil;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_leaf_rate = leaf_r;
  assign out_soil_rate = soil_r;

  // The input is held back only while a finished result waits.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled without a held result");

  // The damping factor never exceeds 1.0 in Q24.
  a_fac_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (fac5_r <= 25'h1000000))
    else $error("damping factor above one");

  // The clamped leaf change stays within 2^40.
  a_leaf_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    vm1_r |-> (mag_m1_r <= lastd_pkg::LEAF_LIM))
    else $error("leaf change beyond clamp");

  // A held result does not move while the output is stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(leaf_r) && $stable(soil_r)))
    else $error("held result changed under stall");

endmodule
`default_nettype wire
